>>> rtl/rsm_pkg.sv
// Shared types and constants for the ratiometric supply monitor.
`default_nettype none
package rsm_pkg;

    localparam int ADC_BITS   = 12;
    localparam int MV_W       = 16;
    localparam int CAL_MV_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = ADC_BITS + MV_W;
    localparam int DIV_BITS   = CAL_MV_W + MV_W;
    localparam int DIV_STEPS  = DIV_BITS / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [MV_W-1:0]     UNCAL_CODE  = 16'hFFFF;
    localparam logic [MV_W-1:0]     UNCAL_SUBST = 16'd1510;
    localparam logic [MV_W-1:0]     MV_SAT      = 16'hFFFF;

    localparam logic [MV_W-1:0]     RST_CAL_WORD = 16'hFFFF;
    localparam logic [CAL_MV_W-1:0] RST_CAL_MV   = 12'd3000;
    localparam logic [MV_W-1:0]     RST_BATT_MIN = 16'd2500;
    localparam logic [MV_W-1:0]     RST_BATT_MAX = 16'd7000;
    localparam logic [MV_W-1:0]     RST_FALLBACK = 16'd3300;

    localparam logic [CFG_IDX_W-1:0] CFG_CAL_WORD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MV   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATT_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BATT_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 3'd4;

    localparam logic [1:0] OP_REF   = 2'd0;
    localparam logic [1:0] OP_BATT  = 2'd1;
    localparam logic [1:0] OP_SOLAR = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [ADC_BITS-1:0] sample;
        logic [ADC_BITS-1:0] ref_sample;
    } t_in;

    typedef struct packed {
        logic [MV_W-1:0] value_mv;
        logic [MV_W-1:0] supply_mv;
        logic            stale;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_POSTDIV,
        ST_MUL,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic div_end;
        logic mul;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       sample_zero;
        logic       ref_zero;
        logic       cache_zero;
        logic       div_last;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

>>> rtl/rsm_ctrl.sv
// Controller state machine sequencing decode, divide, scale and result transfer.
`default_nettype none
module rsm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire rsm_pkg::t_sts i_sts,
    output rsm_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);
    import rsm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_sts.op == OP_CLEAR) begin
                    n_state = ST_FINISH;
                end else if (i_sts.op == OP_REF) begin
                    if (!i_sts.cache_zero || i_sts.sample_zero) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_DIV;
                    end
                end else if (i_sts.sample_zero) begin
                    n_state = ST_FINISH;
                end else if (!i_sts.cache_zero || i_sts.ref_zero) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = ST_POSTDIV;
                end
            end
            ST_POSTDIV: begin
                n_state = (i_sts.op == OP_REF) ? ST_FINISH : ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_DECODE: begin
                // start the divide only when the supply must be recomputed
                if (i_sts.op == OP_REF) begin
                    o_cmd.div_start = i_sts.cache_zero && !i_sts.sample_zero;
                end else if (i_sts.op != OP_CLEAR) begin
                    o_cmd.div_start = !i_sts.sample_zero && i_sts.cache_zero
                                      && !i_sts.ref_zero;
                end
            end
            ST_DIV:     o_cmd.div_step = 1'b1;
            ST_POSTDIV: o_cmd.div_end  = 1'b1;
            ST_MUL:     o_cmd.mul      = 1'b1;
            ST_FINISH:  o_cmd.finish   = i_sts.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/rsm_dp.sv
// Datapath: configuration, supply cache, serial divider, scaling and battery window.
`default_nettype none
module rsm_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rsm_pkg::t_in                i_in_data,
    input  wire logic                        i_out_stall,
    input  wire logic                        i_cfg_we,
    input  wire logic [rsm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rsm_pkg::MV_W-1:0]    i_cfg_data,
    input  wire rsm_pkg::t_cmd               i_cmd,
    output rsm_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    output rsm_pkg::t_out                    o_out_data
);
    import rsm_pkg::*;

    // configuration
    logic [MV_W-1:0]     r_cal_word;
    logic [CAL_MV_W-1:0] r_cal_mv;
    logic [MV_W-1:0]     r_batt_min;
    logic [MV_W-1:0]     r_batt_max;
    logic [MV_W-1:0]     r_fallback;

    // state
    logic [MV_W-1:0] r_cache;
    logic [MV_W-1:0] r_last_good;
    logic            r_have_good;
    logic            r_stale;

    // item and work registers
    t_in                  r_item;
    logic [ADC_BITS-1:0]  r_div;
    logic [ADC_BITS-1:0]  r_rem;
    logic [DIV_BITS-1:0]  r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]    r_prod;

    // output register
    logic r_out_valid;
    t_out r_out;

    logic [MV_W-1:0]     cal_code;
    logic [ADC_BITS-1:0] n_rem;
    logic [DIV_BITS-1:0] n_quo;
    logic [MV_W-1:0]     quo_sat;
    logic [MV_W-1:0]     vdd;
    logic [MV_W-1:0]     scaled_mv;
    logic [MV_W:0]       doubled;
    logic [MV_W-1:0]     raw_mv;
    logic                plausible;
    t_out                n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_word <= RST_CAL_WORD;
            r_cal_mv   <= RST_CAL_MV;
            r_batt_min <= RST_BATT_MIN;
            r_batt_max <= RST_BATT_MAX;
            r_fallback <= RST_FALLBACK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAL_WORD: r_cal_word <= i_cfg_data;
                CFG_CAL_MV:   r_cal_mv   <= i_cfg_data[CAL_MV_W-1:0];
                CFG_BATT_MIN: r_batt_min <= i_cfg_data;
                CFG_BATT_MAX: r_batt_max <= i_cfg_data;
                CFG_FALLBACK: r_fallback <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cal_code = (r_cal_word == UNCAL_CODE) ? UNCAL_SUBST : r_cal_word;

    // two restoring divide steps per cycle
    always_comb begin
        logic [ADC_BITS:0] trial;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_quo[DIV_BITS-1]};
            n_quo = {n_quo[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                trial    = trial - {1'b0, r_div};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[ADC_BITS-1:0];
        end
    end

    assign quo_sat = (|r_quo[DIV_BITS-1:MV_W]) ? MV_SAT : r_quo[MV_W-1:0];
    assign vdd     = (r_cache == '0) ? r_fallback : r_cache;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.div_start) begin
            r_div <= (r_item.opcode == OP_REF) ? r_item.sample : r_item.ref_sample;
            r_rem <= '0;
            r_quo <= DIV_BITS'(r_cal_mv * cal_code);
            r_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_item.sample * vdd);
        end
    end

    assign scaled_mv = r_prod[PROD_W-1:ADC_BITS];
    assign doubled   = {scaled_mv, 1'b0};

    always_comb begin
        if (r_item.sample == '0) begin
            raw_mv = '0;
        end else if (r_item.opcode == OP_BATT) begin
            raw_mv = doubled[MV_W] ? MV_SAT : doubled[MV_W-1:0];
        end else begin
            raw_mv = scaled_mv;
        end
    end

    assign plausible = (raw_mv >= r_batt_min) && (raw_mv <= r_batt_max);

    always_comb begin
        n_out = '0;
        case (r_item.opcode)
            OP_REF: begin
                n_out.value_mv  = r_cache;
                n_out.supply_mv = r_cache;
                n_out.stale     = r_stale;
            end
            OP_BATT: begin
                n_out.value_mv  = (!plausible && r_have_good) ? r_last_good : raw_mv;
                n_out.supply_mv = r_cache;
                n_out.stale     = !plausible;
            end
            OP_SOLAR: begin
                n_out.value_mv  = raw_mv;
                n_out.supply_mv = r_cache;
                n_out.stale     = r_stale;
            end
            default: begin
                n_out.value_mv  = '0;
                n_out.supply_mv = '0;
                n_out.stale     = r_stale;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache     <= '0;
            r_last_good <= '0;
            r_have_good <= 1'b0;
            r_stale     <= 1'b1;
        end else begin
            if (i_cmd.div_end) begin
                r_cache <= quo_sat;
            end else if (i_cmd.finish && r_item.opcode == OP_CLEAR) begin
                r_cache <= '0;
            end
            if (i_cmd.finish && r_item.opcode == OP_BATT) begin
                r_stale <= !plausible;
                if (plausible) begin
                    r_last_good <= raw_mv;
                    r_have_good <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_sts.op          = r_item.opcode;
    assign o_sts.sample_zero = (r_item.sample == '0);
    assign o_sts.ref_zero    = (r_item.ref_sample == '0);
    assign o_sts.cache_zero  = (r_cache == '0);
    assign o_sts.div_last    = (r_cnt == '0);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

>>> rtl/ratiometric_supply_monitor.sv
// After the input transfer, a clear, a failed read or a cached reference goes from decode straight to
// the result register; a scale on a known supply passes the multiply first, a reference divide the
// serial divide, and a scale with a divide both. The supply divide runs two quotient bits a cycle over
// its 28-bit dividend. Throughput: one item at a time, the next taken in the idle state after the
// previous result is registered. Reset (synchronous, active low) restores register defaults,
// empties the supply cache, clears the last good battery value and marks the battery stale.
`default_nettype none
module ratiometric_supply_monitor (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire rsm_pkg::t_in                  i_in_data,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output rsm_pkg::t_out                      o_out_data,
    input  wire logic                          i_out_stall,
    input  wire logic                          i_cfg_we,
    input  wire logic [rsm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rsm_pkg::MV_W-1:0]      i_cfg_data
);
    import rsm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    rsm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTH
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a transfer");

    a_finish_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over a pending result");

    a_finish_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_out_valid)
        else $error("finished result not presented");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.div_start, cmd.div_step, cmd.div_end, cmd.mul, cmd.finish}))
        else $error("controller issued overlapping commands");
`endif

endmodule
`default_nettype wire

>>> tb/tb_ratiometric_supply_monitor.sv
// Self-checking testbench for the ratiometric supply monitor: directed corners, then random traffic.
`default_nettype none
module tb_ratiometric_supply_monitor;
    import rsm_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in                  i_in_data   = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out                 o_out_data;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [MV_W-1:0]      i_cfg_data  = '0;

    ratiometric_supply_monitor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Local copy of the register file and the monitor state
    logic [MV_W-1:0]     cal_word_r;
    logic [CAL_MV_W-1:0] cal_mv_r;
    logic [MV_W-1:0]     win_lo;
    logic [MV_W-1:0]     win_hi;
    logic [MV_W-1:0]     fallback_r;
    logic [MV_W-1:0]     cache_mv;
    logic [MV_W-1:0]     good_mv;
    logic                good_valid;
    logic                stale_flag;

    t_out expected_q[$];
    int   errors       = 0;
    int   checked      = 0;
    int   stale_seen   = 0;
    int   setups       = 0;
    int   op_count[4]  = '{0, 0, 0, 0};
    logic no_idle      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Timeout at %0t with %0d results outstanding", $time, expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [MV_W-1:0] sat_mv(input logic [63:0] v);
        return (v > 64'(MV_SAT)) ? MV_SAT : v[MV_W-1:0];
    endfunction

    // Cached supply, or a fresh one from the reference conversion
    function automatic logic [MV_W-1:0] supply_lookup(input logic [ADC_BITS-1:0] rs);
        logic [MV_W-1:0] code;
        logic [MV_W-1:0] mv;
        if (cache_mv != '0)
            return cache_mv;
        if (rs == '0) begin
            mv = '0;
        end else begin
            code = (cal_word_r == UNCAL_CODE) ? UNCAL_SUBST : cal_word_r;
            mv   = sat_mv((64'(cal_mv_r) * 64'(code)) / 64'(rs));
        end
        cache_mv = mv;
        return mv;
    endfunction

    function automatic logic [MV_W-1:0] scale_mv(input logic [ADC_BITS-1:0] s,
                                                 input logic [ADC_BITS-1:0] rs,
                                                 input int unsigned mult);
        logic [MV_W-1:0] vdd;
        logic [63:0]     v;
        if (s == '0)
            return '0;
        vdd = supply_lookup(rs);
        if (vdd == '0)
            vdd = fallback_r;
        v = (64'(s) * 64'(vdd)) >> ADC_BITS;
        return sat_mv(v * 64'(mult));
    endfunction

    function automatic t_out predict_reading(input t_in it);
        t_out            res;
        logic [MV_W-1:0] val;
        case (it.opcode)
            OP_REF: begin
                val = supply_lookup(it.sample);
            end
            OP_BATT: begin
                val = scale_mv(it.sample, it.ref_sample, 2);
                if (val >= win_lo && val <= win_hi) begin
                    good_mv    = val;
                    good_valid = 1'b1;
                    stale_flag = 1'b0;
                end else begin
                    // hold the last good reading when one exists
                    stale_flag = 1'b1;
                    if (good_valid)
                        val = good_mv;
                end
            end
            OP_SOLAR: begin
                val = scale_mv(it.sample, it.ref_sample, 1);
            end
            default: begin
                cache_mv = '0;
                val      = '0;
            end
        endcase
        res.value_mv  = val;
        res.supply_mv = cache_mv;
        res.stale     = stale_flag;
        return res;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result value_mv=%0d supply_mv=%0d stale=%0b",
                         $time, o_out_data.value_mv, o_out_data.supply_mv,
                         o_out_data.stale);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                checked++;
                if (o_out_data.stale)
                    stale_seen++;
                if (o_out_data.value_mv !== exp_r.value_mv) begin
                    $display("%0t: value_mv expected %0d actual %0d",
                             $time, exp_r.value_mv, o_out_data.value_mv);
                    errors++;
                end
                if (o_out_data.supply_mv !== exp_r.supply_mv) begin
                    $display("%0t: supply_mv expected %0d actual %0d",
                             $time, exp_r.supply_mv, o_out_data.supply_mv);
                    errors++;
                end
                if (o_out_data.stale !== exp_r.stale) begin
                    $display("%0t: stale expected %0b actual %0b",
                             $time, exp_r.stale, o_out_data.stale);
                    errors++;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk)
        i_out_stall <= !no_idle && ($urandom_range(0, 99) < 14);

    task automatic send_item(input t_in item);
        if (!no_idle && $urandom_range(0, 99) < 14) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.push_back(predict_reading(item));
        op_count[item.opcode]++;
    endtask

    task automatic send_op(input logic [1:0] op, input int s, input int rs);
        t_in it;
        it.opcode     = op;
        it.sample     = s[ADC_BITS-1:0];
        it.ref_sample = rs[ADC_BITS-1:0];
        send_item(it);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [MV_W-1:0] cw, input logic [MV_W-1:0] cmv,
                                 input logic [MV_W-1:0] lo, input logic [MV_W-1:0] hi,
                                 input logic [MV_W-1:0] fb);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CAL_WORD;
        i_cfg_data <= cw;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CAL_MV;
        i_cfg_data <= cmv;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BATT_MIN;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BATT_MAX;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FALLBACK;
        i_cfg_data <= fb;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cal_word_r = cw;
        cal_mv_r   = cmv[CAL_MV_W-1:0];
        win_lo     = lo;
        win_hi     = hi;
        fallback_r = fb;
        setups++;
    endtask

    function automatic logic [ADC_BITS-1:0] rand_sample();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return '0;
        if (pick < 15) return '1;
        if (pick < 25) return ADC_BITS'($urandom_range(1, 15));
        return ADC_BITS'($urandom);
    endfunction

    function automatic t_in rand_item();
        t_in         it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)      it.opcode = OP_REF;
        else if (pick < 55) it.opcode = OP_BATT;
        else if (pick < 85) it.opcode = OP_SOLAR;
        else                it.opcode = OP_CLEAR;
        it.sample     = rand_sample();
        it.ref_sample = rand_sample();
        return it;
    endfunction

    // Reset defaults: zero reference, fallback, failed reads, saturation, clear
    task automatic test_reset_defaults();
        send_op(OP_REF,   0,    0);
        send_op(OP_BATT,  4095, 0);
        send_op(OP_SOLAR, 0,    4095);
        send_op(OP_BATT,  0,    4095);
        send_op(OP_REF,   1,    0);
        send_op(OP_SOLAR, 4095, 0);
        send_op(OP_BATT,  4095, 0);
        send_op(OP_CLEAR, 4095, 4095);
        send_op(OP_BATT,  4095, 1500);
        send_op(OP_SOLAR, 1,    4095);
        send_op(OP_CLEAR, 0,    0);
        send_op(OP_SOLAR, 2048, 4095);
        wait_idle();
    endtask

    // Register extremes: zero code, window edges, inverted window, zero fallback
    task automatic test_register_extremes();
        load_settings(16'd0, 16'd4095, MV_SAT, MV_SAT, MV_SAT);
        send_op(OP_CLEAR, 0,    0);
        send_op(OP_REF,   4095, 0);
        send_op(OP_BATT,  4095, 4095);
        send_op(OP_SOLAR, 4095, 4095);
        wait_idle();
        // upper data bits of the 12-bit register must be dropped
        load_settings(16'd65534, 16'hFFFF, 16'd7000, 16'd2500, 16'd0);
        send_op(OP_CLEAR, 0,    0);
        send_op(OP_REF,   4095, 0);
        send_op(OP_BATT,  4095, 4095);
        send_op(OP_CLEAR, 0,    0);
        send_op(OP_BATT,  100,  0);
        wait_idle();
        load_settings(16'd1, 16'd0, 16'd0, 16'd0, 16'd1);
        send_op(OP_CLEAR, 0,    0);
        send_op(OP_REF,   7,    0);
        send_op(OP_BATT,  4095, 5);
        send_op(OP_SOLAR, 4095, 3);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int unsigned pick;
        int          lo;
        int          hi;
        int          swap;
        logic [MV_W-1:0] cw;
        logic [MV_W-1:0] fb;
        for (int phase = 0; phase < 12; phase++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3)      cw = UNCAL_CODE;
            else if (pick < 4) cw = '0;
            else if (pick < 7) cw = MV_W'($urandom_range(1200, 1800));
            else               cw = MV_W'($urandom);
            lo = $urandom_range(0, 20000);
            hi = lo + $urandom_range(0, 45535);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end else if (pick == 1) begin
                lo = 0;
                hi = 65535;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)      fb = '0;
            else if (pick == 1) fb = MV_SAT;
            else                fb = MV_W'($urandom);
            load_settings(cw, {4'($urandom), CAL_MV_W'($urandom)},
                          MV_W'(lo), MV_W'(hi), fb);
            no_idle = (phase == 4);
            repeat (155) send_item(rand_item());
            wait_idle();
            no_idle = 1'b0;
        end
    endtask

    initial begin
        cal_word_r = RST_CAL_WORD;
        cal_mv_r   = RST_CAL_MV;
        win_lo     = RST_BATT_MIN;
        win_hi     = RST_BATT_MAX;
        fallback_r = RST_FALLBACK;
        cache_mv   = '0;
        good_mv    = '0;
        good_valid = 1'b0;
        stale_flag = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic();

        $display("Checked %0d results: %0d reference, %0d battery, %0d solar, %0d clear",
                 checked, op_count[OP_REF], op_count[OP_BATT], op_count[OP_SOLAR],
                 op_count[OP_CLEAR]);
        $display("Stale battery flags seen: %0d, register settings applied: %0d",
                 stale_seen, setups);
        if (errors == 0 && expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
